// File: sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wave stream parser
// result word layout, controller and datapath interfaces, tags and codes
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_NOT_RIFF  = 4'd2;
  localparam logic [3:0] ST_PAST_END  = 4'd3;
  localparam logic [3:0] ST_FMT_SMALL = 4'd4;
  localparam logic [3:0] ST_EXT_SMALL = 4'd5;
  localparam logic [3:0] ST_EXT_LEN   = 4'd6;
  localparam logic [3:0] ST_SUBFMT    = 4'd7;
  localparam logic [3:0] ST_NO_FMT    = 4'd8;
  localparam logic [3:0] ST_NO_DATA   = 4'd9;
  localparam logic [3:0] ST_BAD_TAG   = 4'd10;
  localparam logic [3:0] ST_FLOAT_W   = 4'd11;
  localparam logic [3:0] ST_PARTIAL   = 4'd12;
  localparam logic [3:0] ST_PCM_DEPTH = 4'd13;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT   = 16'hfffe;

  localparam logic [5:0]  MIN_FILE    = 6'd44;
  localparam logic [31:0] EXT_FMT_MIN = 32'd40;
  localparam logic [15:0] EXT_LEN_MIN = 16'd22;
  localparam logic [31:0] FMT_MIN     = 32'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        is_float;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [3:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic exec;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic       need_div;
    logic       div_done;
    logic [1:0] res_count;
  } stat_t;

  // tail of the subformat guid, bytes 28 to 39 of the fmt payload
  function automatic logic [7:0] guid_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd2:    v = 8'h10;
      4'd4:    v = 8'h80;
      4'd7:    v = 8'haa;
      4'd9:    v = 8'h38;
      4'd10:   v = 8'h9b;
      4'd11:   v = 8'h71;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: sv/wave_stream_parser.sv
// ----------------------------------------------------------------------------
// wave_stream_parser: streaming riff/wave pcm and float parser
// one file byte per input word, format info, samples and a final status out
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in       sink       byte_value_i, end_of_file_i
//  out      source     kind_o, sample_value_o, sample_is_float_o, channel_count_o,
//                      rate_hz_o, sample_bits_o, status_code_o, last_result_o
//
// a byte passes through intake, then commit, then one delivery state per result word
// delivered; a byte makes at most two result words
// the data chunk header adds, once per file, a wait for the serial remainder
// check of the chunk length against the bytes per sample
// reset puts the parser at the riff tag; the end-of-file byte returns it there
// a stalled output holds the controller in its delivery state, no byte is taken
// ----------------------------------------------------------------------------
module wave_stream_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_value_i,
  input  logic               end_of_file_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] sample_value_o,
  output logic               sample_is_float_o,
  output logic [15:0]        channel_count_o,
  output logic [31:0]        rate_hz_o,
  output logic [15:0]        sample_bits_o,
  output logic [3:0]         status_code_o,
  output logic               last_result_o
);
  import wsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  // controller: handshakes and step sequencing
  wsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: parse state, fmt capture and the result registers
  wsp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .byte_value_i  (byte_value_i),
    .end_of_file_i (end_of_file_i),
    .res_o         (res)
  );

  assign kind_o            = res.kind;
  assign sample_value_o    = signed'(res.value);
  assign sample_is_float_o = res.is_float;
  assign channel_count_o   = res.channels;
  assign rate_hz_o         = res.rate;
  assign sample_bits_o     = res.bits;
  assign status_code_o     = res.status;
  assign last_result_o     = res.last;

endmodule

// File: sv/wsp_rem.sv
// ----------------------------------------------------------------------------
// wsp_rem: serial remainder unit
// one quotient bit per cycle, tells whether a 32-bit length divides evenly
// ----------------------------------------------------------------------------
module wsp_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [12:0] divisor_i,
  output logic        done_o,
  output logic        rem_zero_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [13:0] rem_q, rem_d;
  logic [12:0] div_q, div_d;
  logic [13:0] trial;

  assign trial = {rem_q[12:0], num_q[31]};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
      num_d = {num_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == 14'd0);

endmodule

// File: sv/wsp_dp.sv
// ----------------------------------------------------------------------------
// wsp_dp: parser datapath
// holds the parse state and fmt fields, works out one byte and its results
// ----------------------------------------------------------------------------
module wsp_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsp_pkg::cmd_t cmd_i,
  output wsp_pkg::stat_t stat_o,
  input  logic [7:0]    byte_value_i,
  input  logic          end_of_file_i,
  output wsp_pkg::res_t res_o
);
  import wsp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE, PH_FMT, PH_DATA, PH_SKIP, PH_PAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  seen_q, seen_d;
  logic [31:0] fpos_q, fpos_d, tag_q, tag_d, clen_q, clen_d, rate_q, rate_d;
  logic [31:0] samp_q, samp_d;
  logic [15:0] ftag_q, ftag_d, ch_q, ch_d, width_q, width_d, ext_q, ext_d;
  logic [1:0]  sub_q, sub_d, sidx_q, sidx_d;
  logic [3:0]  err_q, err_d;
  logic        started_q, started_d;
  logic [7:0]  byte_q;
  logic        eof_q;
  res_t        r0_q, r1_q, r0_d, r1_d;
  logic [1:0]  n_d;
  logic        rem_zero, div_done;
  logic [31:0] new_len;

  assign new_len = {byte_q, clen_q[31:8]};

  wsp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (new_len),
    .divisor_i  (width_q[15:3]),
    .done_o     (div_done),
    .rem_zero_o (rem_zero)
  );

  assign stat_o.need_div = (err_q == 4'd0) && (phase_q == PH_SIZE) && (fpos_q == 32'd3)
                           && (tag_q == TAG_DATA) && !started_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.res_count = n_d;

  always_comb begin
    logic        fin;
    logic [3:0]  code;
    logic [3:0]  e;
    logic [31:0] sn;
    logic [2:0]  bps;
    logic [3:0]  st;
    res_t        r;
    phase_d   = phase_q;
    seen_d    = seen_q;
    fpos_d    = fpos_q;
    tag_d     = tag_q;
    clen_d    = clen_q;
    ftag_d    = ftag_q;
    ch_d      = ch_q;
    rate_d    = rate_q;
    width_d   = width_q;
    ext_d     = ext_q;
    sub_d     = sub_q;
    samp_d    = samp_q;
    sidx_d    = sidx_q;
    err_d     = err_q;
    started_d = started_q;
    r0_d      = '0;
    r1_d      = '0;
    n_d       = 2'd0;
    fin       = 1'b0;
    code      = ST_OK;
    e         = ST_OK;
    sn        = {byte_q, samp_q[31:8]};
    bps       = width_q[5:3];
    st        = ST_OK;
    r         = '0;

    if (seen_q < MIN_FILE) seen_d = seen_q + 6'd1;

    if (err_q == 4'd0) begin
      case (phase_q)
        PH_RIFF, PH_RSIZE, PH_WAVE: begin
          tag_d  = {byte_q, tag_q[31:8]};
          fpos_d = fpos_q + 32'd1;
          if (fpos_q == 32'd3) begin
            fpos_d = '0;
            if ((phase_q == PH_RIFF && tag_d != TAG_RIFF)
                || (phase_q == PH_WAVE && tag_d != TAG_WAVE)) begin
              err_d = ST_NOT_RIFF;
            end else if (phase_q == PH_WAVE) begin
              phase_d = PH_ID;
            end else if (phase_q == PH_RIFF) begin
              phase_d = PH_RSIZE;
            end else begin
              phase_d = PH_WAVE;
            end
            tag_d = '0;
          end
        end
        PH_ID: begin
          tag_d  = {byte_q, tag_q[31:8]};
          fpos_d = fpos_q + 32'd1;
          if (fpos_q == 32'd3) begin
            fpos_d  = '0;
            clen_d  = '0;
            phase_d = PH_SIZE;
          end
        end
        PH_SIZE: begin
          clen_d = new_len;
          fpos_d = fpos_q + 32'd1;
          if (fpos_q == 32'd3) begin
            fpos_d = '0;
            if (tag_q == TAG_FMT && !started_q) begin
              phase_d = PH_FMT;
              sub_d   = 2'b11;
              ext_d   = '0;
              fin     = (clen_d == 32'd0);
            end else if (tag_q == TAG_DATA && !started_q) begin
              if (ftag_q == 16'd0 || ch_q == 16'd0 || rate_q == 32'd0 || width_q == 16'd0)
                code = ST_NO_FMT;
              else if (clen_d == 32'd0)
                code = ST_NO_DATA;
              else if (ftag_q != FMT_PCM && ftag_q != FMT_FLOAT)
                code = ST_BAD_TAG;
              else if (ftag_q == FMT_FLOAT && width_q != 16'd32)
                code = ST_FLOAT_W;
              else if (width_q[15:3] == 13'd0 || !rem_zero)
                code = ST_PARTIAL;
              else if (width_q != 16'd16 && width_q != 16'd24 && width_q != 16'd32)
                code = ST_PCM_DEPTH;
              started_d  = 1'b1;
              r.kind     = KIND_FORMAT;
              r.is_float = (ftag_q == FMT_FLOAT);
              r.channels = ch_q;
              r.rate     = rate_q;
              r.bits     = width_q;
              r.status   = code;
              r0_d       = r;
              n_d        = 2'd1;
              if (code != ST_OK) begin
                err_d = code;
              end else begin
                phase_d = PH_DATA;
                samp_d  = '0;
                sidx_d  = '0;
                fin     = (clen_d == 32'd0);
              end
            end else begin
              phase_d = PH_SKIP;
              fin     = (clen_d == 32'd0);
            end
          end
        end
        PH_FMT, PH_DATA, PH_SKIP: begin
          if (phase_q == PH_FMT) begin
            if (fpos_q < 32'd2) begin
              if (fpos_q[0]) ftag_d[15:8] = byte_q;
              else           ftag_d[7:0]  = byte_q;
            end else if (fpos_q < 32'd4) begin
              if (fpos_q[0]) ch_d[15:8] = byte_q;
              else           ch_d[7:0]  = byte_q;
            end else if (fpos_q < 32'd8) begin
              case (fpos_q[1:0])
                2'd0:    rate_d[7:0]   = byte_q;
                2'd1:    rate_d[15:8]  = byte_q;
                2'd2:    rate_d[23:16] = byte_q;
                default: rate_d[31:24] = byte_q;
              endcase
            end else if (fpos_q == 32'd14) begin
              width_d[7:0] = byte_q;
            end else if (fpos_q == 32'd15) begin
              width_d[15:8] = byte_q;
            end else if (fpos_q == 32'd16) begin
              ext_d[7:0] = byte_q;
            end else if (fpos_q == 32'd17) begin
              ext_d[15:8] = byte_q;
            end else if (fpos_q == 32'd24) begin
              if (byte_q != FMT_PCM[7:0])   sub_d[0] = 1'b0;
              if (byte_q != FMT_FLOAT[7:0]) sub_d[1] = 1'b0;
            end else if (fpos_q >= 32'd25 && fpos_q < 32'd28) begin
              if (byte_q != 8'd0) sub_d = 2'b00;
            end else if (fpos_q >= 32'd28 && fpos_q < 32'd40) begin
              if (byte_q != guid_byte(4'(fpos_q - 32'd28))) sub_d = 2'b00;
            end
          end
          if (phase_q == PH_DATA) begin
            if ({1'b0, sidx_q} + 3'd1 >= bps) begin
              r.kind     = KIND_SAMPLE;
              r.value    = sn;
              r.is_float = (ftag_q == FMT_FLOAT);
              r.bits     = width_q;
              r0_d       = r;
              n_d        = 2'd1;
              samp_d     = '0;
              sidx_d     = '0;
            end else begin
              samp_d = sn;
              sidx_d = sidx_q + 2'd1;
            end
          end
          fpos_d = fpos_q + 32'd1;
          clen_d = clen_q - 32'd1;
          fin    = (clen_d == 32'd0);
        end
        default: begin
          phase_d = PH_ID;
          fpos_d  = '0;
          tag_d   = '0;
        end
      endcase

      // end of a chunk payload, fmt checks land here
      if (fin) begin
        if (phase_d == PH_FMT) begin
          if (fpos_d < FMT_MIN) begin
            e = ST_FMT_SMALL;
          end else if (ftag_d == FMT_EXT) begin
            if (fpos_d < EXT_FMT_MIN)    e = ST_EXT_SMALL;
            else if (ext_d < EXT_LEN_MIN) e = ST_EXT_LEN;
            else if (sub_d[0])            ftag_d = FMT_PCM;
            else if (sub_d[1])            ftag_d = FMT_FLOAT;
            else                          e = ST_SUBFMT;
          end
        end
        if (e != ST_OK) begin
          err_d = e;
        end else begin
          phase_d = fpos_d[0] ? PH_PAD : PH_ID;
          fpos_d  = '0;
          tag_d   = '0;
        end
      end
    end

    if (eof_q) begin
      if (err_d != 4'd0)
        st = err_d;
      else if (seen_d < MIN_FILE)
        st = ST_SHORT;
      else if ((phase_d == PH_FMT || phase_d == PH_DATA || phase_d == PH_SKIP)
               && clen_d != 32'd0)
        st = ST_PAST_END;
      else if (!started_d)
        st = ST_NO_DATA;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      r.last   = 1'b1;
      if (n_d == 2'd0) r0_d = r;
      else             r1_d = r;
      n_d       = n_d + 2'd1;
      phase_d   = PH_RIFF;
      seen_d    = '0;
      fpos_d    = '0;
      tag_d     = '0;
      clen_d    = '0;
      ftag_d    = '0;
      ch_d      = '0;
      rate_d    = '0;
      width_d   = '0;
      ext_d     = '0;
      sub_d     = 2'b11;
      samp_d    = '0;
      sidx_d    = '0;
      err_d     = '0;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RIFF;
      seen_q    <= '0;
      fpos_q    <= '0;
      tag_q     <= '0;
      clen_q    <= '0;
      ftag_q    <= '0;
      ch_q      <= '0;
      rate_q    <= '0;
      width_q   <= '0;
      ext_q     <= '0;
      sub_q     <= 2'b11;
      samp_q    <= '0;
      sidx_q    <= '0;
      err_q     <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.exec) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      fpos_q    <= fpos_d;
      tag_q     <= tag_d;
      clen_q    <= clen_d;
      ftag_q    <= ftag_d;
      ch_q      <= ch_d;
      rate_q    <= rate_d;
      width_q   <= width_d;
      ext_q     <= ext_d;
      sub_q     <= sub_d;
      samp_q    <= samp_d;
      sidx_q    <= sidx_d;
      err_q     <= err_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= byte_value_i;
      eof_q  <= end_of_file_i;
    end
    if (cmd_i.exec) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
  end

  assign res_o = cmd_i.sel ? r1_q : r0_q;

endmodule

// File: sv/wsp_ctrl.sv
// ----------------------------------------------------------------------------
// wsp_ctrl: parser controller
// sequences byte intake, the remainder check and the delivery of results
// ----------------------------------------------------------------------------
module wsp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wsp_pkg::stat_t stat_i,
  output wsp_pkg::cmd_t  cmd_o
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {C_IN, C_EXEC, C_DIV, C_OUT0, C_OUT1} ctrl_e;

  ctrl_e      state_q;
  logic       div_ok_q;
  logic [1:0] cnt_q;

  assign in_ready_o  = (state_q == C_IN);
  assign out_valid_o = (state_q == C_OUT0) || (state_q == C_OUT1);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == C_IN) && in_valid_i;
    cmd_o.start_div = (state_q == C_EXEC) && stat_i.need_div && !div_ok_q;
    cmd_o.exec      = (state_q == C_EXEC) && !(stat_i.need_div && !div_ok_q);
    cmd_o.sel       = (state_q == C_OUT1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IN;
      div_ok_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      case (state_q)
        C_IN: if (in_valid_i) state_q <= C_EXEC;
        C_EXEC: begin
          if (cmd_o.start_div) begin
            state_q <= C_DIV;
          end else begin
            div_ok_q <= 1'b0;
            cnt_q    <= stat_i.res_count;
            state_q  <= (stat_i.res_count != 2'd0) ? C_OUT0 : C_IN;
          end
        end
        C_DIV: begin
          if (stat_i.div_done) begin
            div_ok_q <= 1'b1;
            state_q  <= C_EXEC;
          end
        end
        C_OUT0: if (out_ready_i) state_q <= (cnt_q == 2'd2) ? C_OUT1 : C_IN;
        C_OUT1: if (out_ready_i) state_q <= C_IN;
        default: state_q <= C_IN;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("intake and delivery overlap");

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !cmd_o.exec) else $error("byte committed twice");

  a_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_OUT1) |-> (cnt_q == 2'd2)) else $error("second word without a pair");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_div |=> (state_q == C_DIV)) else $error("remainder start lost");

endmodule
